// ===== rtl/sipt_pkg.sv =====
// Shared types, constants and helpers for the sorted ID prefix table.
// No dependencies; imported by every other file in rtl/.
`default_nettype none

package sipt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ID_CHARS    = 6;
  localparam int ID_W        = 8 * ID_CHARS;
  localparam int LEN_W       = 3;
  localparam int TITLE_W     = 16;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 3;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_NONE  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EXACT = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXT   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABBR  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RES,
    S_DEL,
    S_INS
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DN,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [TITLE_W-1:0] title;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0] q;
    logic [ID_W-1:0] pm;
  } query_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic ext;
    logic ab;
  } cell_flags_t;

  typedef struct packed {
    logic             del;
    logic             ins;
    logic [CNT_W-1:0] idx;
    entry_t           fresh;
  } mut_t;

  typedef struct packed {
    logic [CNT_W-1:0]   beg;
    logic [CNT_W-1:0]   fin;
    logic               at_eq;
    logic               at_ext;
    logic               at_ab;
    logic               prev_ab;
    logic [TITLE_W-1:0] t_at;
    logic [TITLE_W-1:0] t_prev;
  } find_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    id_chars;
    logic [LEN_W-1:0]   id_length;
    logic [TITLE_W-1:0] title_handle;
    logic               remove_all_extended;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   position;
    logic [CNT_W-1:0]   match_count;
    logic [TITLE_W-1:0] title_out;
  } out_t;

  // Mask covering the first len characters (top bytes); saturates at ID_CHARS.
  function automatic logic [ID_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ID_W-1:0] m;
    m = '0;
    for (int b = 0; b < ID_CHARS; b++) begin
      if (b < int'(len)) begin
        m[ID_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sipt_cell.sv =====
// One table slot: stored entry, neighbour shift and registered compare flags.
// Depends on sipt_pkg.
`default_nettype none

module sipt_cell
  import sipt_pkg::*;
(
  input  logic        clk,
  input  cell_op_t    op,
  input  entry_t      from_dn,
  input  entry_t      from_up,
  input  entry_t      fresh,
  input  query_t      query,
  input  logic        valid,
  output entry_t      entry,
  output cell_flags_t flags
);

  entry_t      entry_r, entry_nxt;
  cell_flags_t flags_r, flags_nxt;
  logic [ID_W-1:0] masked;

  always_comb begin
    case (op)
      CELL_TAKE_UP: entry_nxt = from_up;
      CELL_TAKE_DN: entry_nxt = from_dn;
      CELL_LOAD:    entry_nxt = fresh;
      default:      entry_nxt = entry_r;
    endcase
  end

  always_comb begin
    masked        = entry_r.id & query.pm;
    flags_nxt.lt  = valid && (masked < query.q);
    flags_nxt.eq  = valid && (masked == query.q);
    flags_nxt.ext = |(entry_r.id & ~query.pm);
    // stored ID is a prefix of the query
    flags_nxt.ab  = valid && ((query.q & prefix_mask(entry_r.len)) == entry_r.id);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    flags_r <= flags_nxt;
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

// ===== rtl/sipt_row.sv =====
// Row of table cells with per-slot shift control and boundary encoding.
// Depends on sipt_pkg and sipt_cell.
`default_nettype none

module sipt_row
  import sipt_pkg::*;
(
  input  logic             clk,
  input  query_t           query,
  input  mut_t             mut,
  input  logic [CNT_W-1:0] count,
  output find_t            found
);

  entry_t      ent [TABLE_DEPTH];
  cell_flags_t flg [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt, le;
  logic [TABLE_DEPTH:0]   fb, fe;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_op_t op;
    entry_t   dn, up;
    logic     valid;

    if (i == 0) begin : g_dn0
      assign dn = '0;
    end else begin : g_dn
      assign dn = ent[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_up0
      assign up = '0;
    end else begin : g_up
      assign up = ent[i+1];
    end

    assign valid = CNT_W'(i) < count;

    always_comb begin
      if (mut.del && (CNT_W'(i) >= mut.idx)) begin
        op = CELL_TAKE_UP;
      end else if (mut.ins && (CNT_W'(i) > mut.idx)) begin
        op = CELL_TAKE_DN;
      end else if (mut.ins && (CNT_W'(i) == mut.idx)) begin
        op = CELL_LOAD;
      end else begin
        op = CELL_HOLD;
      end
    end

    sipt_cell u_cell (
      .clk     (clk),
      .op      (op),
      .from_dn (dn),
      .from_up (up),
      .fresh   (mut.fresh),
      .query   (query),
      .valid   (valid),
      .entry   (ent[i]),
      .flags   (flg[i])
    );

    assign lt[i] = flg[i].lt;
    assign le[i] = flg[i].lt | flg[i].eq;
  end

  // lt and le are thermometer codes over a sorted table: mark their edges
  always_comb begin
    fb[0] = !lt[0];
    fe[0] = !le[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      fb[i] = lt[i-1] & !lt[i];
      fe[i] = le[i-1] & !le[i];
    end
    fb[TABLE_DEPTH] = lt[TABLE_DEPTH-1];
    fe[TABLE_DEPTH] = le[TABLE_DEPTH-1];
  end

  always_comb begin
    found = '0;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      found.beg = found.beg | (fb[i] ? CNT_W'(i) : '0);
      found.fin = found.fin | (fe[i] ? CNT_W'(i) : '0);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found.at_eq   = found.at_eq   | (fb[i] & flg[i].eq);
      found.at_ext  = found.at_ext  | (fb[i] & flg[i].eq & flg[i].ext);
      found.at_ab   = found.at_ab   | (fb[i] & flg[i].ab);
      found.prev_ab = found.prev_ab | (fb[i+1] & flg[i].ab);
      found.t_at    = found.t_at    | ({TITLE_W{fb[i]}} & ent[i].title);
      found.t_prev  = found.t_prev  | ({TITLE_W{fb[i+1]}} & ent[i].title);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_id_prefix_table.sv =====
// Sorted ID prefix table: top level with sequencer, query and result registers.
// Depends on sipt_pkg and sipt_row (which holds the sipt_cell chain).
`default_nettype none

// Sorted table of up to 256 IDs (1 to 6 characters, zero padded) with a
// 16-bit title each, held in a row of cells that all compare against the
// query in parallel. Word flow: a word is taken on in_valid & in_ready,
// the cells compare in the next cycle and the result word is formed in the
// cycle after and loaded into the output register once free; no new word
// is taken until the block is back in idle. Inserts and removes then
// update the table one neighbour shift per cycle: a remove shifts once
// per deleted entry, an insert once per entry it sweeps out (the ID itself
// and its extensions) plus once to open the slot. in_ready is low until
// the update is done. The output register holds the result until taken;
// the block stalls in the resolve cycle only while an earlier result is
// still waiting.
// Slots above the entry count are ignored, so no clearing pass is needed
// after reset. cfg_wdata sets lookup_enable (reset 1); write it only while
// the block is idle.
module sorted_id_prefix_table
  import sipt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,

  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,

  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,

  input  logic cfg_we,
  input  logic cfg_wdata
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             lookup_en_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] del_left_r, del_left_nxt;
  logic             ins_pend_r, ins_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  // captured word
  logic [MODE_W-1:0]  mode_r;
  logic [ID_W-1:0]    q_r, pm_r;
  logic [LEN_W-1:0]   len_r;
  logic [TITLE_W-1:0] handle_r;
  logic               all_r;

  logic             accept;
  logic [LEN_W-1:0] len_c;
  query_t           query;
  mut_t             mut;
  find_t            found;

  // resolved result
  logic [STAT_W-1:0]  find_stat;
  logic [CNT_W-1:0]   find_pos, num, rm_idx;
  logic [TITLE_W-1:0] t_find;
  logic               full;
  out_t               res_out;
  logic [CNT_W-1:0]   res_del;
  logic               res_ins;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign len_c    = (in_data.id_length > LEN_W'(ID_CHARS)) ? LEN_W'(ID_CHARS)
                                                           : in_data.id_length;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_data.mode;
      pm_r     <= prefix_mask(len_c);
      q_r      <= in_data.id_chars & prefix_mask(len_c);
      len_r    <= len_c;
      handle_r <= in_data.title_handle;
      all_r    <= in_data.remove_all_extended;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_en_r <= 1'b1;
    end else if (cfg_we) begin
      lookup_en_r <= cfg_wdata;
    end
  end

  assign query.q  = q_r;
  assign query.pm = pm_r;

  assign mut.del   = (state_r == S_DEL);
  assign mut.ins   = (state_r == S_INS);
  assign mut.idx   = idx_r;
  assign mut.fresh = '{id: q_r, len: len_r, title: handle_r};

  sipt_row u_row (
    .clk   (clk),
    .query (query),
    .mut   (mut),
    .count (count_r),
    .found (found)
  );

  // Search outcome. The matching run starts at beg and ends at fin; an
  // abbreviation is either the slot at beg or the one just below it.
  always_comb begin
    if (found.at_eq) begin
      find_stat = found.at_ext ? STAT_EXT : STAT_EXACT;
      find_pos  = found.beg;
    end else if (found.at_ab) begin
      find_stat = STAT_ABBR;
      find_pos  = found.beg;
    end else if (found.prev_ab) begin
      find_stat = STAT_ABBR;
      find_pos  = found.beg - CNT_W'(1);
    end else begin
      find_stat = STAT_NONE;
      find_pos  = found.beg;
    end
    num    = found.fin - found.beg;
    t_find = (found.at_eq || found.at_ab) ? found.t_at : found.t_prev;
    // insert / remove work just past an abbreviation
    rm_idx = (find_stat == STAT_ABBR) ? find_pos + CNT_W'(1) : find_pos;
  end

  always_comb begin
    res_out = '0;
    res_del = '0;
    res_ins = 1'b0;
    full    = 1'b0;
    case (mode_r)
      MODE_LOOKUP: begin
        res_out.title_out = handle_r;
        if (len_r != '0 && lookup_en_r) begin
          res_out.status      = find_stat;
          res_out.position    = find_pos;
          res_out.match_count = num;
          if (find_stat != STAT_NONE) begin
            res_out.title_out = t_find;
          end
        end
      end
      MODE_INSERT: begin
        if (len_r != '0) begin
          // the ID and all its extensions go first
          res_del = found.at_eq ? num : '0;
          full    = (count_r - res_del) == CNT_W'(TABLE_DEPTH);
          res_ins = !full;
          res_out.status      = full ? STAT_FULL : find_stat;
          res_out.position    = rm_idx;
          res_out.match_count = res_del;
          res_out.title_out   = full ? '0 : handle_r;
        end
      end
      MODE_REMOVE: begin
        if (len_r != '0) begin
          if (found.at_eq) begin
            // without the all flag only a full-length match goes
            res_del = all_r ? num : (found.at_ext ? '0 : CNT_W'(1));
          end
          res_out.status      = find_stat;
          res_out.position    = rm_idx;
          res_out.match_count = res_del;
          res_out.title_out   = (res_del != '0) ? found.t_at : '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    del_left_nxt  = del_left_r;
    ins_pend_nxt  = ins_pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        // wait here while the previous result is still unread
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_out;
          idx_nxt       = rm_idx;
          del_left_nxt  = res_del;
          ins_pend_nxt  = res_ins;
          if (res_del != '0) begin
            state_nxt = S_DEL;
          end else if (res_ins) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DEL: begin
        // one entry closed up per cycle at idx
        count_nxt    = count_r - CNT_W'(1);
        del_left_nxt = del_left_r - CNT_W'(1);
        if (del_left_r == CNT_W'(1)) begin
          state_nxt = ins_pend_r ? S_INS : S_IDLE;
        end
      end
      S_INS: begin
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      del_left_r  <= '0;
      ins_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      del_left_r  <= del_left_nxt;
      ins_pend_r  <= ins_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== dv/sorted_id_prefix_table_tb.sv =====
// Self-checking bench for sorted_id_prefix_table: random and directed words with idling on both sides.
// Needs rtl/sipt_pkg.sv and the RTL of the block; a scoreboard class predicts every result word.
`timescale 1ns / 1ps

module sorted_id_prefix_table_tb;
  import sipt_pkg::*;

  // Mode 3 has no name in the package; the block must answer it with all zeros.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int unsigned STALL_LIMIT   = 4000; // cycles with no handshake at all
  localparam int unsigned LONG_HOLD     = 300;  // receiver hold-off, fills the block
  localparam int unsigned SETTLE_CYCLES = 300;  // worst table shuffle after a result
  localparam int unsigned MAX_GAP       = 15;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the table, predicts one result word per input word.
  // ---------------------------------------------------------------------------
  class id_table_scoreboard;
    logic [ID_W-1:0]    ids    [TABLE_DEPTH];
    logic [LEN_W-1:0]   lens   [TABLE_DEPTH];
    logic [TITLE_W-1:0] titles [TABLE_DEPTH];
    int unsigned        count;
    bit                 lookup_en;
    out_t               due_results [$];
    int unsigned        errors;

    function void clear();
      count     = 0;
      lookup_en = 1'b1;
      errors    = 0;
      due_results.delete();
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Ones over the first len characters, first character in the top byte.
    function logic [ID_W-1:0] char_mask(int unsigned len);
      logic [ID_W-1:0] ones;
      ones = {ID_W{1'b1}};
      if (len > ID_CHARS) len = ID_CHARS;
      return ~(ones >> (8 * len));
    endfunction

    // Entry i is a shorter ID that the query starts with.
    function bit is_prefix_of_query(int unsigned i, logic [ID_W-1:0] q);
      return (q & char_mask(lens[i])) == ids[i];
    endfunction

    // First entry at or above the query's leading characters, or the abbreviation just below; span = run of matches.
    function int unsigned locate(logic [ID_W-1:0] q, int unsigned len,
                                 output logic [STAT_W-1:0] stat,
                                 output int unsigned span);
      logic [ID_W-1:0] pm;
      logic [ID_W-1:0] qp;
      int unsigned     beg;
      int unsigned     k;
      pm  = char_mask(len);
      qp  = q & pm;
      beg = 0;
      for (k = 0; k < count; k++) begin
        if ((ids[k] & pm) < qp) beg++;
      end
      stat = STAT_NONE;
      if (beg < count && (ids[beg] & pm) == qp) begin
        stat = ((ids[beg] & ~pm) != '0) ? STAT_EXT : STAT_EXACT;
      end else if (beg < count && is_prefix_of_query(beg, q)) begin
        stat = STAT_ABBR;
      end else if (beg > 0 && is_prefix_of_query(beg - 1, q)) begin
        // the entry just below the insertion point, also at the table's end
        stat = STAT_ABBR;
        beg--;
      end
      k = beg;
      while (k < count && (ids[k] & pm) == qp) k++;
      span = k - beg;
      return beg;
    endfunction

    // Delete the exact entry, or it and all extensions; returns the slot index.
    function int unsigned drop(logic [ID_W-1:0] q, int unsigned len, bit all,
                               output logic [STAT_W-1:0] stat,
                               output int unsigned gone,
                               output logic [TITLE_W-1:0] first_title);
      int unsigned span;
      int unsigned idx;
      int unsigned cut;
      idx         = locate(q, len, stat, span);
      gone        = 0;
      first_title = '0;
      if (stat == STAT_ABBR) begin
        idx++;
      end else if (stat == STAT_EXACT || stat == STAT_EXT) begin
        // without all, a lone extension is left alone
        cut = all ? span : ((ids[idx] == q) ? 1 : 0);
        if (cut > 0 && idx + cut <= count) begin
          first_title = titles[idx];
          for (int unsigned k = idx; k + cut < count; k++) begin
            ids[k]    = ids[k + cut];
            lens[k]   = lens[k + cut];
            titles[k] = titles[k + cut];
          end
          count = count - cut;
          gone  = cut;
        end
      end
      return idx;
    endfunction

    function out_t predict_result(in_t w);
      out_t               r;
      int unsigned        len;
      int unsigned        pos;
      int unsigned        cnt;
      logic [ID_W-1:0]    q;
      logic [STAT_W-1:0]  stat;
      logic [TITLE_W-1:0] title;
      logic [TITLE_W-1:0] dropped_title;
      len   = (w.id_length > ID_CHARS) ? ID_CHARS : w.id_length;
      q     = w.id_chars & char_mask(len);
      stat  = STAT_NONE;
      pos   = 0;
      cnt   = 0;
      title = '0;
      case (w.mode)
        MODE_LOOKUP: begin
          title = w.title_handle;
          if (len != 0 && lookup_en) begin
            pos = locate(q, len, stat, cnt);
            if (stat != STAT_NONE && pos < count) title = titles[pos];
          end
        end
        MODE_INSERT: begin
          if (len != 0) begin
            pos = drop(q, len, 1'b1, stat, cnt, dropped_title);
            if (count >= TABLE_DEPTH || pos > count) begin
              stat  = STAT_FULL;
              title = '0;
            end else begin
              for (int unsigned k = count; k > pos; k--) begin
                ids[k]    = ids[k - 1];
                lens[k]   = lens[k - 1];
                titles[k] = titles[k - 1];
              end
              ids[pos]    = q;
              lens[pos]   = LEN_W'(len);
              titles[pos] = w.title_handle;
              count++;
              title = w.title_handle;
            end
          end
        end
        MODE_REMOVE: begin
          if (len != 0) pos = drop(q, len, w.remove_all_extended, stat, cnt, title);
        end
        default: ;
      endcase
      r.status      = stat;
      r.position    = CNT_W'(pos);
      r.match_count = CNT_W'(cnt);
      r.title_out   = title;
      return r;
    endfunction

    function void note_word(in_t w);
      due_results.push_back(predict_result(w));
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: result word with none pending: status %0h position %0h count %0h title %0h",
                 $time, got.status, got.position, got.match_count, got.title_out);
        return;
      end
      want = due_results.pop_front();
      flag_field("status", want.status, got.status);
      flag_field("position", want.position, got.position);
      flag_field("match_count", want.match_count, got.match_count);
      flag_field("title_out", want.title_out, got.title_out);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and hookup
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  bit          tx_idle;       // sender draws gaps
  bit          rx_idle;       // receiver draws stalls
  bit          hold_request;  // raised by the stimulus, served by the receiver
  int unsigned rx_stall;
  int unsigned quiet_cycles;

  id_table_scoreboard sb;
  logic [ID_W-1:0]    fill_ids [$];

  sorted_id_prefix_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sampling at the rising edge, before the block's own updates land. Result
  // check first, then the newly taken word is predicted; the two can never be
  // the same word since the block registers both the word and the compare flags.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_word(out_data);
        rx_stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (in_valid && in_ready) sb.note_word(in_data);
      // watchdog: any handshake restarts the count
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: per-word random stall, plus the long hold-off counted here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic in_t mk_word(logic [MODE_W-1:0] mode, logic [ID_W-1:0] chars,
                                  int unsigned len, logic [TITLE_W-1:0] title, bit all);
    in_t w;
    w.mode                = mode;
    w.id_chars            = chars;
    w.id_length           = LEN_W'(len);
    w.title_handle        = title;
    w.remove_all_extended = all;
    return w;
  endfunction

  function automatic logic [ID_W-1:0] id_of(string s);
    logic [ID_W-1:0] v;
    v = '0;
    for (int b = 0; b < s.len() && b < ID_CHARS; b++) v[ID_W-1-8*b -: 8] = s[b];
    return v;
  endfunction

  // Small alphabet so prefixes, extensions and abbreviations turn up often;
  // now and then a zero or wild character, and junk past the length.
  function automatic logic [ID_W-1:0] pick_chars(int unsigned len);
    logic [ID_W-1:0] v;
    logic [7:0]      ch;
    v = ID_W'({$urandom, $urandom});
    if ($urandom_range(0, 19) == 0) return v;
    for (int b = 0; b < ID_CHARS; b++) begin
      if (b < len) begin
        case ($urandom_range(0, 19))
          0:       ch = 8'h00;
          1:       ch = 8'($urandom);
          default: ch = "A" + 8'($urandom_range(0, 2));
        endcase
      end else begin
        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
      end
      v[ID_W-1-8*b -: 8] = ch;
    end
    return v;
  endfunction

  // Full-length IDs from D to Z: distinct from the small alphabet tree.
  function automatic logic [ID_W-1:0] letter_id();
    logic [ID_W-1:0] v;
    for (int b = 0; b < ID_CHARS; b++) v[ID_W-1-8*b -: 8] = "D" + 8'($urandom_range(0, 22));
    return v;
  endfunction

  function automatic in_t random_word();
    int unsigned       r;
    int unsigned       len;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(0, 99);
    if (r < 40)      mode = MODE_INSERT;
    else if (r < 75) mode = MODE_LOOKUP;
    else if (r < 97) mode = MODE_REMOVE;
    else             mode = MODE_SPARE;
    r = $urandom_range(0, 99);
    if (r < 2)      len = 0;
    else if (r < 4) len = 7;  // above the ID size, clamps
    else            len = $urandom_range(1, $urandom_range(1, ID_CHARS));
    return mk_word(mode, pick_chars(len), len, TITLE_W'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap; valid stays up until taken, and is not
  // dropped between back-to-back words.
  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Sender pauses until every pending result word is back, then lets the
  // table shuffle that follows the last result finish.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lookup_enable(input bit en);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.lookup_en = en;
  endtask

  task automatic run_random(input int unsigned n, input bit with_hold);
    for (int unsigned k = 0; k < n; k++) begin
      // idling pattern changes every 40 words, including stretches with none
      if (k % 40 == 0) {tx_idle, rx_idle} = 2'($urandom_range(0, 3));
      if (with_hold && k == n / 2) begin
        // receiver goes quiet while the sender keeps pushing back to back
        hold_request = 1'b1;
        tx_idle      = 1'b0;
      end
      send_word(random_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_t             w;
    logic [ID_W-1:0] old_id;
    sb = new();
    sb.clear();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_request = 1'b0;
    rx_stall     = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_lookup_enable(1'b1);

    // Directed: empty table, the four lookup outcomes, both remove flavours,
    // extremes of ID and length, zero characters, empty ID and spare mode.
    send_word(mk_word(MODE_LOOKUP, id_of("AB"), 2, 16'h5A5A, 1'b0));
    send_word(mk_word(MODE_INSERT, id_of("AB"), 2, 16'hFFFF, 1'b0));
    send_word(mk_word(MODE_INSERT, id_of("ABCD"), 4, 16'h1234, 1'b0));
    send_word(mk_word(MODE_INSERT, id_of("ABX"), 3, 16'h0000, 1'b1));
    send_word(mk_word(MODE_INSERT, id_of("B"), 1, 16'h00AA, 1'b0));
    send_word(mk_word(MODE_LOOKUP, id_of("A"), 1, 16'h1111, 1'b0));      // extension
    send_word(mk_word(MODE_LOOKUP, id_of("AB"), 2, 16'h2222, 1'b0));     // exact
    send_word(mk_word(MODE_LOOKUP, id_of("ABCDEF"), 6, 16'h3333, 1'b0)); // abbreviation
    send_word(mk_word(MODE_LOOKUP, id_of("ZZ"), 2, 16'h4444, 1'b0));     // miss past the end
    send_word(mk_word(MODE_LOOKUP, id_of("BQ"), 2, 16'h5555, 1'b0));     // abbrev at the end
    send_word(mk_word(MODE_REMOVE, id_of("A"), 1, 16'h0000, 1'b0));      // only extensions
    send_word(mk_word(MODE_REMOVE, id_of("AB"), 2, 16'h0000, 1'b0));     // exact only
    send_word(mk_word(MODE_INSERT, id_of("A"), 1, 16'h8001, 1'b0));      // sweeps extensions
    send_word(mk_word(MODE_REMOVE, id_of("A"), 1, 16'hFFFF, 1'b1));
    send_word(mk_word(MODE_INSERT, {ID_W{1'b1}}, 6, 16'hBEEF, 1'b0));
    send_word(mk_word(MODE_INSERT, {ID_W{1'b1}}, 7, 16'hCAFE, 1'b1));    // length clamps
    send_word(mk_word(MODE_INSERT, '0, 3, 16'h0F0F, 1'b0));              // all-zero chars
    send_word(mk_word(MODE_INSERT, 48'h41_00_42_00_00_00, 3, 16'hF0F0, 1'b0));
    send_word(mk_word(MODE_LOOKUP, 48'h41_00_00_00_00_00, 3, 16'h6666, 1'b0));
    send_word(mk_word(MODE_LOOKUP, id_of("AB"), 0, 16'h7777, 1'b0));     // empty ID
    send_word(mk_word(MODE_INSERT, id_of("AB"), 0, 16'h7777, 1'b1));
    send_word(mk_word(MODE_REMOVE, id_of("B"), 0, 16'h7777, 1'b1));
    send_word(mk_word(MODE_SPARE, {ID_W{1'b1}}, 7, 16'hFFFF, 1'b1));
    send_word(mk_word(MODE_REMOVE, {ID_W{1'b1}}, 6, 16'hFFFF, 1'b0));
    send_word(mk_word(MODE_LOOKUP, 48'h41_FF_FF_FF_FF_FF, 1, 16'h8888, 1'b0)); // junk masked

    run_random(300, 1'b1);

    // lookups disabled: every lookup answers with its own default handle
    write_lookup_enable(1'b0);
    run_random(80, 1'b0);
    write_lookup_enable(1'b1);

    // Fill the table to the brim; the last inserts are refused as full.
    for (int unsigned k = 0; k < 270; k++) begin
      if (k % 40 == 0) {tx_idle, rx_idle} = 2'($urandom_range(0, 3));
      old_id = letter_id();
      fill_ids.push_back(old_id);
      send_word(mk_word(MODE_INSERT, old_id, ID_CHARS, TITLE_W'($urandom), 1'b0));
    end

    // Work on a full table: replace in place, sweep a letter, remove, refuse.
    for (int unsigned k = 0; k < 60; k++) begin
      old_id = fill_ids[$urandom_range(0, fill_ids.size() - 1)];
      case ($urandom_range(0, 5))
        0: w = mk_word(MODE_LOOKUP, old_id, ID_CHARS, TITLE_W'($urandom), 1'b0);
        1: w = mk_word(MODE_LOOKUP, old_id, $urandom_range(1, ID_CHARS - 1),
                       TITLE_W'($urandom), 1'b0);
        2: w = mk_word(MODE_INSERT, old_id, ID_CHARS, TITLE_W'($urandom), 1'b0);
        3: w = mk_word(MODE_INSERT, letter_id(), ID_CHARS, TITLE_W'($urandom), 1'b0);
        4: w = mk_word(MODE_INSERT, old_id, 1, TITLE_W'($urandom), 1'b0);
        default: w = mk_word(MODE_REMOVE, old_id, $urandom_range(1, ID_CHARS),
                             TITLE_W'($urandom), 1'($urandom_range(0, 1)));
      endcase
      send_word(w);
    end

    run_random(250, 1'b1);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
